// File: hw/rtl/sra_pkg.sv
package sra_pkg;

    localparam int DIM_W   = 13;
    localparam int PAD_W   = 8;
    localparam int SUM_W   = DIM_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W = 32;

    localparam int MAX_DIM_DEFAULT = 4096;

    localparam logic [DIM_W-1:0] SHEET_WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] SHEET_HEIGHT_RESET = DIM_W'(1024);
    localparam logic [PAD_W-1:0] PAD_PIXELS_RESET   = PAD_W'(1);

    localparam logic [DIM_W-1:0] STATE_MAX = {DIM_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHEET_WIDTH  = 2'd0,
        CFG_SHEET_HEIGHT = 2'd1,
        CFG_PAD_PIXELS   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] sheet_width;
        logic [DIM_W-1:0] sheet_height;
        logic [PAD_W-1:0] pad_pixels;
    } cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0] cursor_col;
        logic [DIM_W-1:0] cursor_row;
        logic [DIM_W-1:0] shelf_height;
    } shelf_state_t;

    typedef struct packed {
        logic             granted;
        logic [DIM_W-1:0] place_x;
        logic [DIM_W-1:0] place_y;
    } place_result_t;

    // Saturate a grown sum back into a state entry.
    function automatic logic [DIM_W-1:0] sat_state(input logic [SUM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v > SUM_W'(STATE_MAX)) begin
            r = STATE_MAX;
        end else begin
            r = v[DIM_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/sra_cfg_regs.sv
module sra_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sra_pkg::DIM_W-1:0]     cfg_data,
    output sra_pkg::cfg_t                 cfg
);
    import sra_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SHEET_WIDTH:  cfg_next.sheet_width  = cfg_data;
                CFG_SHEET_HEIGHT: cfg_next.sheet_height = cfg_data;
                CFG_PAD_PIXELS:   cfg_next.pad_pixels   = cfg_data[PAD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sheet_width  <= SHEET_WIDTH_RESET;
            cfg_reg.sheet_height <= SHEET_HEIGHT_RESET;
            cfg_reg.pad_pixels   <= PAD_PIXELS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/sra_place_calc.sv
module sra_place_calc #(
    parameter int MAX_DIM = sra_pkg::MAX_DIM_DEFAULT
) (
    input  sra_pkg::cfg_t             cfg,
    input  sra_pkg::shelf_state_t     state_cur,
    input  logic [sra_pkg::DIM_W-1:0] req_width,
    input  logic [sra_pkg::DIM_W-1:0] req_height,
    output sra_pkg::shelf_state_t     state_next,
    output sra_pkg::place_result_t    result
);
    import sra_pkg::*;

    logic [DIM_W-1:0] aw;
    logic [DIM_W-1:0] ah;
    logic [SUM_W-1:0] pad2;
    logic [SUM_W-1:0] pw;
    logic [SUM_W-1:0] ph;
    logic             reject;
    logic             wrap;
    logic             height_fail;
    shelf_state_t     moved;

    always_comb begin
        // The register value only matters up to the largest supported atlas.
        aw = (32'(cfg.sheet_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.sheet_width;
        ah = (32'(cfg.sheet_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.sheet_height;

        pad2 = SUM_W'({cfg.pad_pixels, 1'b0});
        pw   = SUM_W'(req_width) + pad2;
        ph   = SUM_W'(req_height) + pad2;

        reject = (req_width == '0) || (req_height == '0) ||
                 (pw > SUM_W'(aw)) || (ph > SUM_W'(ah));

        wrap = (SUM_W'(state_cur.cursor_col) + pw) > SUM_W'(aw);

        moved = state_cur;
        if (wrap) begin
            moved.cursor_col   = '0;
            moved.cursor_row   = sat_state(SUM_W'(state_cur.cursor_row) +
                                           SUM_W'(state_cur.shelf_height));
            moved.shelf_height = '0;
        end

        height_fail = (SUM_W'(moved.cursor_row) + ph) > SUM_W'(ah);

        state_next     = state_cur;
        result.granted = 1'b0;
        result.place_x = '0;
        result.place_y = '0;

        if (!reject) begin
            // A row change stays in effect even when the height check fails.
            state_next = moved;
            if (!height_fail) begin
                result.granted = 1'b1;
                result.place_x = DIM_W'(SUM_W'(moved.cursor_col) + SUM_W'(cfg.pad_pixels));
                result.place_y = DIM_W'(SUM_W'(moved.cursor_row) + SUM_W'(cfg.pad_pixels));
                state_next.cursor_col = sat_state(SUM_W'(moved.cursor_col) + pw);
                if (ph > SUM_W'(moved.shelf_height)) begin
                    state_next.shelf_height = sat_state(ph);
                end
            end
        end
    end

endmodule

// File: hw/rtl/shelf_rect_allocator_unit.sv
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | s_tdata: req_width, req_height
// m_      | out       | m_tvalid/m_tready  | m_tdata: place_x, place_y; m_tuser: granted
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request is accepted per cycle while s_tready is high; each passes through the request
// register and then the result register. The cursor update is combinational between the
// request register and the result register.
// Reset loads the atlas size and padding defaults and clears the cursor and row height.
// s_tready falls only when both the request and the result registers hold items and
// m_tready is low. cfg_ready is always high.
module shelf_rect_allocator_unit #(
    parameter int MAX_DIM = sra_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sra_pkg::TDATA_W-1:0]   s_tdata,   // [12:0] req_width, [25:13] req_height
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sra_pkg::TDATA_W-1:0]   m_tdata,   // [12:0] place_x, [25:13] place_y
    output logic                          m_tuser,   // [0] granted
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sra_pkg::DIM_W-1:0]     cfg_data
);
    import sra_pkg::*;

    cfg_t             cfg;
    shelf_state_t     state_reg;
    shelf_state_t     state_next;
    place_result_t    calc_result;
    place_result_t    result_reg;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [DIM_W-1:0] in_width_reg;
    logic [DIM_W-1:0] in_height_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             s_accept;
    logic             advance;

    sra_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sra_place_calc #(
        .MAX_DIM (MAX_DIM)
    ) u_calc (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .req_width  (in_width_reg),
        .req_height (in_height_reg),
        .state_next (state_next),
        .result     (calc_result)
    );

    // The request register moves on whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.granted;
    assign m_tdata  = TDATA_W'({result_reg.place_y, result_reg.place_x});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_width_reg  <= s_tdata[DIM_W-1:0];
            in_height_reg <= s_tdata[2*DIM_W-1:DIM_W];
        end
        if (advance) begin
            result_reg <= calc_result;
        end
    end

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("cursor state changed without a request moving on");

    a_grant_moves_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && calc_result.granted) |=> (state_reg.cursor_col != '0))
        else $error("granted placement left the column cursor at zero");

    a_reject_zero_coords: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (result_reg.place_x == '0 && result_reg.place_y == '0))
        else $error("rejected result carries nonzero coordinates");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

endmodule
